// ===== src/serial_frame_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// serial_frame_decoder_macros.svh
// Assertion macros shared by the serial frame decoder RTL.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_DECODER_MACROS_SVH
`define SERIAL_FRAME_DECODER_MACROS_SVH

`ifndef SYNTH
// Checked only outside reset.
`define SFD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("serial_frame_decoder assertion failed");
// Checked in every cycle, reset included.
`define SFD_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("serial_frame_decoder assertion failed");
`else
`define SFD_ASSERT(label, clk, rst, prop)
`define SFD_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== src/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Types, register indexes, status codes and sizes of the serial frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

   localparam int MAX_RAW_BYTES = 511;
   localparam int RAW_W         = $clog2(MAX_RAW_BYTES + 1);
   localparam int DATA_W        = 8;
   localparam int IDX_W         = 9;
   localparam int STATUS_W      = 3;
   localparam int CSR_IDX_W     = 3;

   localparam logic [RAW_W-1:0] RAW_MAX   = RAW_W'(MAX_RAW_BYTES);
   localparam logic [IDX_W-1:0] INDEX_MAX = {IDX_W{1'b1}};

   // raw byte positions within a frame
   localparam logic [RAW_W-1:0] POS_SYNC    = RAW_W'(0);
   localparam logic [RAW_W-1:0] POS_DEST    = RAW_W'(1);
   localparam logic [RAW_W-1:0] POS_LEN     = RAW_W'(2);
   localparam logic [RAW_W-1:0] POS_OK0     = RAW_W'(3);
   localparam logic [RAW_W-1:0] POS_OK1     = RAW_W'(4);
   localparam logic [RAW_W-1:0] HEADER_LEN  = RAW_W'(3);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_CODE    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ESC_MARKER   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_OK_CODE      = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_HOST_ADDRESS = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD  = CSR_IDX_W'(4);

   localparam logic [DATA_W-1:0] RST_SYNC_CODE    = 8'hE0;
   localparam logic [DATA_W-1:0] RST_ESC_MARKER   = 8'hD0;
   localparam logic [DATA_W-1:0] RST_OK_CODE      = 8'h01;
   localparam logic [DATA_W-1:0] RST_HOST_ADDRESS = 8'h00;
   localparam logic [DATA_W-1:0] RST_MAX_PAYLOAD  = 8'hFF;

   // frame status codes
   localparam logic [STATUS_W-1:0] ST_GOOD       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_SYNC   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_WRONG_DEST = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_OK     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = 3'd5;
   localparam logic [STATUS_W-1:0] ST_LEN_MISM   = 3'd6;
   localparam logic [STATUS_W-1:0] ST_BAD_CSUM   = 3'd7;

   typedef struct packed {
      logic [DATA_W-1:0] sync_code;
      logic [DATA_W-1:0] esc_marker;
      logic [DATA_W-1:0] ok_code;
      logic [DATA_W-1:0] host_address;
      logic [DATA_W-1:0] max_payload;
   } cfg_type;

   typedef struct packed {
      logic                valid;
      logic                frame_end;
      logic [DATA_W-1:0]   payload_byte;
      logic [IDX_W-1:0]    payload_index;
      logic [STATUS_W-1:0] frame_status;
   } result_type;

endpackage

// ===== src/serial_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// serial_frame_decoder
// Decodes escaped serial frames into payload bytes and one status per burst.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  req_      in   req_valid/req_ready    req_rx_byte, req_burst_last
//  rsp_      out  rsp_valid/rsp_ready    rsp_frame_end, rsp_payload_byte,
//                                        rsp_payload_index, rsp_frame_status
//  csr_      in   csr_valid/csr_ready    csr_index, csr_data
//
//  One request per cycle while req_ready is high; each result is registered.
//  Input register feeds the decode logic, which writes the result register.
//  Throughput is set by the single decode stage: one byte per clock unless stalled.
//  rsp_ready low with a full result register stalls the decode stage; req_ready
//  drops once the input register is also full. csr_ready is always high.
//  Synchronous reset restores register defaults and re-arms the frame state.
// ----------------------------------------------------------------------------
`include "serial_frame_decoder_macros.svh"

module serial_frame_decoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [sfd_pkg::DATA_W-1:0]       req_rx_byte,
   input  logic                             req_burst_last,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_frame_end,
   output logic [sfd_pkg::DATA_W-1:0]       rsp_payload_byte,
   output logic [sfd_pkg::IDX_W-1:0]        rsp_payload_index,
   output logic [sfd_pkg::STATUS_W-1:0]     rsp_frame_status,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sfd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sfd_pkg::DATA_W-1:0]       csr_data
);

   sfd_pkg::cfg_type    cfg;
   sfd_pkg::result_type result;

   logic                       in_valid_ff, in_valid_in;
   logic [sfd_pkg::DATA_W-1:0] in_byte_ff;
   logic                       in_last_ff;
   logic                       advance;
   logic                       req_accept;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_frame_end_ff;
   logic [sfd_pkg::DATA_W-1:0]   rsp_byte_ff;
   logic [sfd_pkg::IDX_W-1:0]    rsp_index_ff;
   logic [sfd_pkg::STATUS_W-1:0] rsp_status_ff;

   assign csr_ready = 1'b1;

   sfd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = (rsp_valid_ff && !rsp_ready) || (advance && result.valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_rx_byte;
         in_last_ff <= req_burst_last;
      end
      if (advance && result.valid) begin
         rsp_frame_end_ff <= result.frame_end;
         rsp_byte_ff      <= result.payload_byte;
         rsp_index_ff     <= result.payload_index;
         rsp_status_ff    <= result.frame_status;
      end
   end

   sfd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .rx_byte    (in_byte_ff),
      .burst_last (in_last_ff),
      .cfg        (cfg),
      .result     (result)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_end     = rsp_frame_end_ff;
   assign rsp_payload_byte  = rsp_byte_ff;
   assign rsp_payload_index = rsp_index_ff;
   assign rsp_frame_status  = rsp_status_ff;

   `SFD_ASSERT_ALWAYS(a_stall_only_when_full, clock,
      !req_ready |-> (in_valid_ff && rsp_valid_ff && !rsp_ready))

endmodule

// ===== src/sfd_csr.sv =====
// ----------------------------------------------------------------------------
// sfd_csr
// Configuration registers of the serial frame decoder.
// ----------------------------------------------------------------------------
module sfd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [sfd_pkg::CSR_IDX_W-1:0]  wr_index,
   input  logic [sfd_pkg::DATA_W-1:0]     wr_data,
   output sfd_pkg::cfg_type               cfg
);

   sfd_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            sfd_pkg::CSR_SYNC_CODE:    cfg_in.sync_code    = wr_data;
            sfd_pkg::CSR_ESC_MARKER:   cfg_in.esc_marker   = wr_data;
            sfd_pkg::CSR_OK_CODE:      cfg_in.ok_code      = wr_data;
            sfd_pkg::CSR_HOST_ADDRESS: cfg_in.host_address = wr_data;
            sfd_pkg::CSR_MAX_PAYLOAD:  cfg_in.max_payload  = wr_data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_code    <= sfd_pkg::RST_SYNC_CODE;
         cfg_ff.esc_marker   <= sfd_pkg::RST_ESC_MARKER;
         cfg_ff.ok_code      <= sfd_pkg::RST_OK_CODE;
         cfg_ff.host_address <= sfd_pkg::RST_HOST_ADDRESS;
         cfg_ff.max_payload  <= sfd_pkg::RST_MAX_PAYLOAD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/sfd_decode.sv =====
// ----------------------------------------------------------------------------
// sfd_decode
// Frame state and per-byte decode: unescaping, checksum and status checks.
// ----------------------------------------------------------------------------
`include "serial_frame_decoder_macros.svh"

module sfd_decode (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [sfd_pkg::DATA_W-1:0]  rx_byte,
   input  logic                        burst_last,
   input  sfd_pkg::cfg_type            cfg,
   output sfd_pkg::result_type         result
);

   logic [sfd_pkg::RAW_W-1:0]  raw_count_ff, raw_count_in;
   logic [sfd_pkg::DATA_W-1:0] length_ff, length_in;
   logic                       escape_ff, escape_in;
   logic [sfd_pkg::DATA_W-1:0] sum_ff, sum_in;
   logic [sfd_pkg::IDX_W-1:0]  decoded_ff, decoded_in;
   logic                       sync_ok_ff, sync_ok_in;
   logic                       dest_ok_ff, dest_ok_in;
   logic [1:0]                 status_ok_ff, status_ok_in;

   logic [sfd_pkg::RAW_W-1:0]  count;
   logic [sfd_pkg::RAW_W-1:0]  len_plus;
   logic [sfd_pkg::DATA_W-1:0] hdr_sum;
   logic [sfd_pkg::DATA_W-1:0] dec_byte;
   logic [sfd_pkg::DATA_W-1:0] chk;
   logic [sfd_pkg::IDX_W:0]    dec_plus;
   logic                       in_body;
   logic                       ok3, ok4;
   logic [sfd_pkg::STATUS_W-1:0] status;

   always_comb begin
      count   = (raw_count_ff < sfd_pkg::RAW_MAX) ? raw_count_ff + 1'b1 : raw_count_ff;
      in_body = (raw_count_ff >= sfd_pkg::POS_OK0);

      sync_ok_in   = sync_ok_ff;
      dest_ok_in   = dest_ok_ff;
      length_in    = length_ff;
      status_ok_in = status_ok_ff;
      hdr_sum      = sum_ff;
      if (raw_count_ff == sfd_pkg::POS_SYNC) begin
         sync_ok_in = (rx_byte == cfg.sync_code);
      end else if (raw_count_ff == sfd_pkg::POS_DEST) begin
         dest_ok_in = (rx_byte == cfg.host_address);
         hdr_sum    = sum_ff + rx_byte;
      end else if (raw_count_ff == sfd_pkg::POS_LEN) begin
         length_in = rx_byte;
         hdr_sum   = sum_ff + rx_byte;
      end else begin
         if (raw_count_ff == sfd_pkg::POS_OK0 && rx_byte == cfg.ok_code) begin
            status_ok_in[0] = 1'b1;
         end
         if (raw_count_ff == sfd_pkg::POS_OK1 && rx_byte == cfg.ok_code) begin
            status_ok_in[1] = 1'b1;
         end
      end

      // frame status on the last byte of a burst
      len_plus = sfd_pkg::RAW_W'(length_in) + sfd_pkg::HEADER_LEN;
      dec_plus = {1'b0, decoded_ff} + 1'b1;
      chk      = in_body ? rx_byte : '0;
      ok3      = (count > sfd_pkg::POS_OK0) ? status_ok_in[0] : (cfg.ok_code == '0);
      ok4      = (count > sfd_pkg::POS_OK1) ? status_ok_in[1] : (cfg.ok_code == '0);
      if (!(count > sfd_pkg::POS_LEN && count == len_plus)) begin
         status = sfd_pkg::ST_INCOMPLETE;
      end else if (!sync_ok_in) begin
         status = sfd_pkg::ST_BAD_SYNC;
      end else if (!dest_ok_in) begin
         status = sfd_pkg::ST_WRONG_DEST;
      end else if (!ok3 || !ok4) begin
         status = sfd_pkg::ST_NOT_OK;
      end else if (length_in > cfg.max_payload) begin
         status = sfd_pkg::ST_TOO_LARGE;
      end else if (dec_plus != (sfd_pkg::IDX_W + 1)'(length_in)) begin
         status = sfd_pkg::ST_LEN_MISM;
      end else if (hdr_sum != chk) begin
         status = sfd_pkg::ST_BAD_CSUM;
      end else begin
         status = sfd_pkg::ST_GOOD;
      end

      dec_byte = escape_ff ? rx_byte + 1'b1 : rx_byte;

      result       = '0;
      raw_count_in = count;
      escape_in    = escape_ff;
      sum_in       = hdr_sum;
      decoded_in   = decoded_ff;
      if (burst_last) begin
         result.valid        = 1'b1;
         result.frame_end    = 1'b1;
         result.frame_status = status;
         raw_count_in = '0;
         length_in    = '0;
         escape_in    = 1'b0;
         sum_in       = '0;
         decoded_in   = '0;
         sync_ok_in   = 1'b0;
         dest_ok_in   = 1'b0;
         status_ok_in = '0;
      end else if (in_body) begin
         if (rx_byte == cfg.esc_marker) begin
            escape_in = 1'b1;
         end else begin
            escape_in            = 1'b0;
            sum_in               = sum_ff + dec_byte;
            result.valid         = 1'b1;
            result.payload_byte  = dec_byte;
            result.payload_index = decoded_ff;
            if (decoded_ff != sfd_pkg::INDEX_MAX) begin
               decoded_in = decoded_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_count_ff <= '0;
         length_ff    <= '0;
         escape_ff    <= 1'b0;
         sum_ff       <= '0;
         decoded_ff   <= '0;
         sync_ok_ff   <= 1'b0;
         dest_ok_ff   <= 1'b0;
         status_ok_ff <= '0;
      end else if (advance) begin
         raw_count_ff <= raw_count_in;
         length_ff    <= length_in;
         escape_ff    <= escape_in;
         sum_ff       <= sum_in;
         decoded_ff   <= decoded_in;
         sync_ok_ff   <= sync_ok_in;
         dest_ok_ff   <= dest_ok_in;
         status_ok_ff <= status_ok_in;
      end
   end

   `SFD_ASSERT(a_rearm_after_status, clock, reset,
      (advance && burst_last) |=> (raw_count_ff == '0 && decoded_ff == '0 && !escape_ff))
   `SFD_ASSERT(a_escape_cleared_by_payload, clock, reset,
      (advance && result.valid && !result.frame_end) |=> !escape_ff)
   `SFD_ASSERT(a_count_steps, clock, reset,
      (advance && !burst_last && raw_count_ff < sfd_pkg::RAW_MAX)
         |=> (raw_count_ff == $past(raw_count_ff) + 1'b1))

endmodule

// ===== tb/sv/serial_frame_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_decoder_tb
// Sends serial bursts (well-formed frames with random content, escaped and
// corrupted frames, truncated bursts, noise and one overlong burst) through
// the decoder under several register settings. A frame tracker predicts
// every decoded byte and frame status and checks the results in order.
// ----------------------------------------------------------------------------
module serial_frame_decoder_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 130;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      logic                         frame_end;
      logic [sfd_pkg::DATA_W-1:0]   payload_byte;
      logic [sfd_pkg::IDX_W-1:0]    payload_index;
      logic [sfd_pkg::STATUS_W-1:0] frame_status;
   } frame_result_type;

   typedef enum {
      FK_GOOD, FK_ESCAPED, FK_BAD_SYNC, FK_WRONG_DEST, FK_NOT_OK,
      FK_BAD_LENGTH, FK_BAD_CSUM, FK_TRUNCATED, FK_NOISE, FK_LONG
   } frame_kind_type;

   class frame_tracker_type;
      logic [sfd_pkg::DATA_W-1:0] sync_code, esc_marker, ok_code;
      logic [sfd_pkg::DATA_W-1:0] host_address, max_payload;
      logic [sfd_pkg::RAW_W-1:0]  raw_count;
      logic [sfd_pkg::DATA_W-1:0] length_field;
      logic                       escape_pending;
      logic [sfd_pkg::DATA_W-1:0] frame_sum;
      logic [sfd_pkg::IDX_W-1:0]  decoded_count;
      logic                       sync_ok, dest_ok;
      logic [1:0]                 ok_bytes;
      frame_result_type           awaited[$];
      int                         errors;

      function new();
         sync_code    = sfd_pkg::RST_SYNC_CODE;
         esc_marker   = sfd_pkg::RST_ESC_MARKER;
         ok_code      = sfd_pkg::RST_OK_CODE;
         host_address = sfd_pkg::RST_HOST_ADDRESS;
         max_payload  = sfd_pkg::RST_MAX_PAYLOAD;
         errors       = 0;
         rearm();
      endfunction

      function void rearm();
         raw_count      = '0;
         length_field   = '0;
         escape_pending = 1'b0;
         frame_sum      = '0;
         decoded_count  = '0;
         sync_ok        = 1'b0;
         dest_ok        = 1'b0;
         ok_bytes       = '0;
      endfunction

      function void set_reg(logic [sfd_pkg::CSR_IDX_W-1:0] idx,
                            logic [sfd_pkg::DATA_W-1:0] v);
         case (idx)
            sfd_pkg::CSR_SYNC_CODE:    sync_code = v;
            sfd_pkg::CSR_ESC_MARKER:   esc_marker = v;
            sfd_pkg::CSR_OK_CODE:      ok_code = v;
            sfd_pkg::CSR_HOST_ADDRESS: host_address = v;
            sfd_pkg::CSR_MAX_PAYLOAD:  max_payload = v;
            default: ;
         endcase
      endfunction

      function logic [sfd_pkg::STATUS_W-1:0] frame_verdict(
            logic [sfd_pkg::DATA_W-1:0] rx, int pos, int count);
         logic                       ok3, ok4;
         logic [sfd_pkg::DATA_W-1:0] csum;
         csum = (pos >= 3) ? rx : 8'h00;
         if (!(count > 2 && count == int'(length_field) + 3)) return sfd_pkg::ST_INCOMPLETE;
         if (!sync_ok) return sfd_pkg::ST_BAD_SYNC;
         if (!dest_ok) return sfd_pkg::ST_WRONG_DEST;
         // status bytes that never arrived read as zero
         ok3 = (count > 3) ? ok_bytes[0] : (ok_code == 8'h00);
         ok4 = (count > 4) ? ok_bytes[1] : (ok_code == 8'h00);
         if (!ok3 || !ok4) return sfd_pkg::ST_NOT_OK;
         if (length_field > max_payload) return sfd_pkg::ST_TOO_LARGE;
         if (int'(decoded_count) + 1 != int'(length_field)) return sfd_pkg::ST_LEN_MISM;
         if (frame_sum != csum) return sfd_pkg::ST_BAD_CSUM;
         return sfd_pkg::ST_GOOD;
      endfunction

      function void note_request(logic [sfd_pkg::DATA_W-1:0] rx, logic is_last);
         int                         pos, count;
         logic [sfd_pkg::DATA_W-1:0] dec;
         frame_result_type           r;
         pos = int'(raw_count);
         if (raw_count < sfd_pkg::RAW_MAX) raw_count++;
         count = int'(raw_count);
         if (pos == 0) begin
            sync_ok = (rx == sync_code);
         end else if (pos == 1) begin
            dest_ok = (rx == host_address);
            frame_sum = frame_sum + rx;
         end else if (pos == 2) begin
            length_field = rx;
            frame_sum = frame_sum + rx;
         end else begin
            if (pos == 3 && rx == ok_code) ok_bytes[0] = 1'b1;
            if (pos == 4 && rx == ok_code) ok_bytes[1] = 1'b1;
         end
         if (is_last) begin
            r.frame_end     = 1'b1;
            r.payload_byte  = '0;
            r.payload_index = '0;
            r.frame_status  = frame_verdict(rx, pos, count);
            awaited.push_back(r);
            rearm();
            return;
         end
         if (pos < 3) return;
         if (rx == esc_marker) begin
            escape_pending = 1'b1;
            return;
         end
         dec = escape_pending ? rx + 8'd1 : rx;
         escape_pending = 1'b0;
         frame_sum = frame_sum + dec;
         r.frame_end     = 1'b0;
         r.payload_byte  = dec;
         r.payload_index = decoded_count;
         r.frame_status  = sfd_pkg::ST_GOOD;
         awaited.push_back(r);
         if (decoded_count < sfd_pkg::INDEX_MAX) decoded_count++;
      endfunction

      task report(string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_result(frame_result_type got);
         frame_result_type want;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected result end=%0b byte=%h idx=%0d status=%0d",
                   got.frame_end, got.payload_byte, got.payload_index, got.frame_status));
            return;
         end
         want = awaited.pop_front();
         if (got.frame_end !== want.frame_end || got.payload_byte !== want.payload_byte ||
             got.payload_index !== want.payload_index ||
             got.frame_status !== want.frame_status) begin
            report({$sformatf("got end=%0b byte=%h idx=%0d status=%0d, ",
                              got.frame_end, got.payload_byte, got.payload_index,
                              got.frame_status),
                    $sformatf("want end=%0b byte=%h idx=%0d status=%0d",
                              want.frame_end, want.payload_byte, want.payload_index,
                              want.frame_status)});
         end
      endtask
   endclass

   // bit 8 marks the burst-last byte
   localparam logic [8:0] DIRECTED [25] = '{
      9'h0E0, 9'h000, 9'h003, 9'h001, 9'h001, 9'h105,
      9'h0E0, 9'h000, 9'h006, 9'h001, 9'h001, 9'h0D0, 9'h0D0, 9'h07F, 9'h188,
      9'h0D0, 9'h0D0, 9'h0D0, 9'h0D0, 9'h1FF,
      9'h100,
      9'h0FF, 9'h0FF, 9'h0FF, 9'h100
   };

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [sfd_pkg::DATA_W-1:0]    req_rx_byte = '0;
   logic                          req_burst_last = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_frame_end;
   logic [sfd_pkg::DATA_W-1:0]    rsp_payload_byte;
   logic [sfd_pkg::IDX_W-1:0]     rsp_payload_index;
   logic [sfd_pkg::STATUS_W-1:0]  rsp_frame_status;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [sfd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [sfd_pkg::DATA_W-1:0]    csr_data = '0;

   logic                 no_gaps = 1'b0;
   logic                 hold_rsp = 1'b0;
   int                   items_sent = 0;
   int                   cycle_count = 0;
   frame_tracker_type    tracker = new();

   serial_frame_decoder i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .req_burst_last    (req_burst_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_index (rsp_payload_index),
      .rsp_frame_status  (rsp_frame_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** serial_frame_decoder: FAILED **");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= !hold_rsp && (no_gaps || $urandom_range(99) >= 16);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_result({rsp_frame_end, rsp_payload_byte, rsp_payload_index,
                               rsp_frame_status});
      end
   end

   // called at a falling edge; returns at a falling edge with valid still high
   task send_request(input logic [sfd_pkg::DATA_W-1:0] rx, input logic is_last);
      while (!no_gaps && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_rx_byte    <= rx;
      req_burst_last <= is_last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(rx, is_last);
      items_sent++;
      @(negedge clock);
   endtask

   task write_config(input logic [sfd_pkg::DATA_W-1:0] sync_v, esc_v, ok_v, host_v, max_v);
      logic [sfd_pkg::DATA_W-1:0]    vals [5];
      logic [sfd_pkg::CSR_IDX_W-1:0] idxs [5];
      vals = '{sync_v, esc_v, ok_v, host_v, max_v};
      idxs = '{sfd_pkg::CSR_SYNC_CODE, sfd_pkg::CSR_ESC_MARKER, sfd_pkg::CSR_OK_CODE,
               sfd_pkg::CSR_HOST_ADDRESS, sfd_pkg::CSR_MAX_PAYLOAD};
      for (int i = 0; i < 5; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idxs[i];
         csr_data  <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         tracker.set_reg(idxs[i], vals[i]);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // bytes that give no result may still be in flight once the queue is empty
   task wait_idle(input int settle);
      int waited;
      waited = 0;
      while (tracker.awaited.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (settle) @(posedge clock);
      @(negedge clock);
   endtask

   function frame_kind_type pick_kind();
      int r;
      r = $urandom_range(99);
      if (r < 35) return FK_GOOD;
      if (r < 50) return FK_ESCAPED;
      if (r < 57) return FK_BAD_SYNC;
      if (r < 64) return FK_WRONG_DEST;
      if (r < 71) return FK_NOT_OK;
      if (r < 78) return FK_BAD_LENGTH;
      if (r < 85) return FK_BAD_CSUM;
      if (r < 93) return FK_TRUNCATED;
      return FK_NOISE;
   endfunction

   task send_frame(input frame_kind_type kind);
      logic [sfd_pkg::DATA_W-1:0] raw[$];
      logic [sfd_pkg::DATA_W-1:0] payload[$];
      logic [sfd_pkg::DATA_W-1:0] sum, d, flip;
      int                         n, cut, pos;
      n = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 14);
      flip = 8'($urandom_range(1, 255));
      for (int i = 0; i < n; i++) begin
         d = (i < 2) ? tracker.ok_code : 8'($urandom);
         if (i >= 2 && d == tracker.esc_marker) d = d + 8'd1;
         payload.push_back(d);
      end
      raw.push_back(tracker.sync_code);
      raw.push_back(tracker.host_address);
      raw.push_back(8'h00);
      foreach (payload[i]) begin
         if (kind == FK_ESCAPED && $urandom_range(2) == 0) begin
            raw.push_back(tracker.esc_marker);
            raw.push_back(payload[i] - 8'd1);
         end else begin
            raw.push_back(payload[i]);
         end
      end
      raw[2] = 8'(raw.size() - 2);
      sum = raw[1] + raw[2];
      foreach (payload[i]) sum = sum + payload[i];
      raw.push_back(sum);
      case (kind)
         FK_BAD_SYNC:   raw[0] = raw[0] ^ flip;
         FK_WRONG_DEST: raw[1] = raw[1] ^ flip;
         FK_NOT_OK: begin
            pos = 3 + $urandom_range(1);
            if (pos < raw.size() - 1) raw[pos] = raw[pos] ^ flip;
         end
         FK_BAD_LENGTH: raw[2] = 8'($urandom);
         FK_BAD_CSUM:   raw[raw.size() - 1] = raw[raw.size() - 1] ^ flip;
         FK_TRUNCATED: begin
            cut = $urandom_range(1, raw.size() - 1);
            while (raw.size() > cut) void'(raw.pop_back());
         end
         FK_NOISE: begin
            raw.delete();
            repeat ($urandom_range(1, 12)) raw.push_back(8'($urandom));
         end
         FK_LONG: begin
            // runs both byte counters into saturation
            raw.delete();
            raw.push_back(tracker.sync_code);
            raw.push_back(tracker.host_address);
            raw.push_back(8'($urandom));
            repeat (530) raw.push_back(8'($urandom));
         end
         default: ;
      endcase
      foreach (raw[i]) send_request(raw[i], i == raw.size() - 1);
   endtask

   initial begin
      int phase_start;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[i]) send_request(DIRECTED[i][7:0], DIRECTED[i][8]);
      req_valid <= 1'b0;
      wait_idle(8);

      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: write_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            1: write_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
            2: write_config(sfd_pkg::RST_SYNC_CODE, sfd_pkg::RST_ESC_MARKER,
                            sfd_pkg::RST_OK_CODE, sfd_pkg::RST_HOST_ADDRESS,
                            sfd_pkg::RST_MAX_PAYLOAD);
            4: write_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                            8'hFF);
            5: write_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom_range(3, 10)));
            6: write_config(8'($urandom), 8'($urandom), 8'h00, 8'($urandom),
                            8'($urandom));
            default: write_config(8'($urandom), 8'($urandom), 8'($urandom),
                                  8'($urandom), 8'($urandom));
         endcase
         no_gaps <= (ph == 2);
         if (ph == 1) begin
            fork
               begin
                  @(posedge clock);
                  hold_rsp = 1'b1;
                  repeat (HOLD_CYCLES) @(posedge clock);
                  hold_rsp = 1'b0;
               end
            join_none
         end
         if (ph == 4) send_frame(FK_LONG);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) send_frame(pick_kind());
         req_valid <= 1'b0;
         wait_idle(8);
      end

      wait_idle(10);
      if (tracker.awaited.size() != 0) begin
         tracker.report($sformatf("%0d results never arrived", tracker.awaited.size()));
      end
      if (tracker.errors == 0) begin
         $display("** serial_frame_decoder: PASSED **");
      end else begin
         $display("** serial_frame_decoder: FAILED **");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/sfd_pkg.sv
src/sfd_csr.sv
src/sfd_decode.sv
src/serial_frame_decoder.sv
tb/sv/serial_frame_decoder_tb.sv
